FILE: hdl/tcpq_pkg.sv
// Shared types and constants for the two-class priority queue.
package tcpq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int MAX_NUMBER   = 1023;
  localparam int NUM_W        = 10;
  localparam int COUNT_OUT_W  = 5;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_DEPART = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t          command;
    logic [NUM_W-1:0]   entry_number;
    logic               entry_type;
    logic               urgent;
  } cmd_t;

  typedef struct packed {
    logic                   ok;
    logic [COUNT_OUT_W-1:0] waiting_count;
    logic [COUNT_OUT_W-1:0] urgent_count;
  } res_t;

  typedef struct packed {
    logic             valid;
    logic             urgent;
    logic [NUM_W-1:0] number;
  } slot_t;

  // Per-cycle shift controls broadcast to every cell.
  typedef struct packed {
    logic ins_en;
    logic pop_en;
    logic del_en;
  } ctl_t;

endpackage

FILE: hdl/tcpq_cell.sv
// One queue slot: holds an entry, compares it, and shifts with its neighbors.
module tcpq_cell #(
  parameter int IDX   = 0,
  parameter int POS_W = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [tcpq_pkg::NUM_W-1:0] req_number,
  input  logic                       req_urgent,
  input  logic                       capture,
  input  tcpq_pkg::ctl_t             ctl,
  input  logic [POS_W-1:0]           ins_pos,
  input  tcpq_pkg::slot_t            left,
  input  tcpq_pkg::slot_t            right,
  input  logic                       hit_in,
  input  logic                       hit_urg_in,
  output tcpq_pkg::slot_t            slot,
  output logic                       hit_out,
  output logic                       hit_urg_out
);

  logic match_q;
  logic take_left;
  logic load;
  logic take_right;

  assign take_left  = ctl.ins_en && (POS_W'(IDX) > ins_pos);
  assign load       = ctl.ins_en && (POS_W'(IDX) == ins_pos);
  // a removal closes the gap from the matching cell onward
  assign take_right = ctl.pop_en || (ctl.del_en && (hit_in || match_q));

  assign hit_out     = hit_in || match_q;
  assign hit_urg_out = hit_urg_in || (match_q && slot.urgent);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid  <= 1'b0;
      slot.urgent <= 1'b0;
      match_q     <= 1'b0;
    end else begin
      if (capture) begin
        match_q <= slot.valid && (slot.number == req_number);
      end
      if (take_left) begin
        slot <= left;
      end else if (load) begin
        slot.valid  <= 1'b1;
        slot.urgent <= req_urgent;
        slot.number <= req_number;
      end else if (take_right) begin
        slot <= right;
      end
    end
  end

endmodule

FILE: hdl/two_class_priority_queue_unit.sv
// Two-class priority queue: command channel, result channel, queue type register.
//
// Usage: a request on cmd (valid/stall) carries a command (add, depart,
// remove, query), an entry number, an entry type and an urgent flag. Each
// request yields exactly one result on res (valid/stall) holding ok and the
// total and urgent counts after the command.
// Entries sit in a row of CAPACITY cells kept in service order: urgent first,
// each class first in, first out. An accepted request is registered, compared
// in every cell in the compare state and applied (shift insert or shift remove)
// in the apply state, where the result register is loaded. The compare/apply
// pass through the cell row limits throughput: only one request is in flight,
// and a new request is taken during the apply state, as the result is loaded.
// When res is stalled with a result waiting, the apply step holds and cmd
// stalls until the result is taken; nothing is lost or repeated.
// cfg_wr_en writes queue_type (entry type accepted by add) at any edge.
// Reset (rst, synchronous) empties the queue, zeroes both counts, clears
// queue_type and drops res_valid; no clearing pass is needed.
module two_class_priority_queue_unit #(
  parameter int CAPACITY = tcpq_pkg::CAPACITY_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  tcpq_pkg::cmd_t  cmd,
  output logic            res_valid,
  input  logic            res_stall,
  output tcpq_pkg::res_t  res,
  input  logic            cfg_wr_en,
  input  logic            cfg_wr_data
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_COMPARE = 3'b010,
    ST_APPLY   = 3'b100
  } state_t;

  state_t          state;
  state_t          state_next;
  tcpq_pkg::cmd_t  req;
  logic            queue_type;
  logic [CW-1:0]   total_cnt;
  logic [CW-1:0]   urgent_cnt;
  logic [CW-1:0]   total_cnt_next;
  logic [CW-1:0]   urgent_cnt_next;

  tcpq_pkg::slot_t slots [CAPACITY];
  logic            hit   [CAPACITY+1];
  logic            hit_urg [CAPACITY+1];

  tcpq_pkg::ctl_t  ctl;
  logic [CW-1:0]   ins_pos;
  logic            out_free;
  logic            fire;
  logic            accept;
  logic            found;
  logic            ok;
  logic            in_range;

  assign out_free  = !res_valid || !res_stall;
  assign fire      = (state == ST_APPLY) && out_free;
  assign cmd_stall = !((state == ST_IDLE) || fire);
  assign accept    = cmd_valid && !cmd_stall;

  assign found    = hit[CAPACITY];
  assign ins_pos  = req.urgent ? urgent_cnt : total_cnt;
  assign in_range = (req.entry_number != '0) &&
                    (32'(req.entry_number) <= tcpq_pkg::MAX_NUMBER);

  assign hit[0]     = 1'b0;
  assign hit_urg[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    tcpq_pkg::slot_t left_s;
    tcpq_pkg::slot_t right_s;
    if (i == 0) begin : g_first
      assign left_s = '0;
    end else begin : g_mid
      assign left_s = slots[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_s = '0;
    end else begin : g_inner
      assign right_s = slots[i+1];
    end
    tcpq_cell #(
      .IDX   (i),
      .POS_W (CW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .req_number  (req.entry_number),
      .req_urgent  (req.urgent),
      .capture     (state == ST_COMPARE),
      .ctl         (ctl),
      .ins_pos     (ins_pos),
      .left        (left_s),
      .right       (right_s),
      .hit_in      (hit[i]),
      .hit_urg_in  (hit_urg[i]),
      .slot        (slots[i]),
      .hit_out     (hit[i+1]),
      .hit_urg_out (hit_urg[i+1])
    );
  end

  always_comb begin
    ok              = 1'b0;
    ctl             = '0;
    total_cnt_next  = total_cnt;
    urgent_cnt_next = urgent_cnt;
    case (req.command)
      tcpq_pkg::CMD_ADD: begin
        ok = (total_cnt != CW'(CAPACITY)) && !found && (req.entry_type == queue_type);
        ctl.ins_en      = fire && ok;
        total_cnt_next  = total_cnt + CW'(1);
        urgent_cnt_next = urgent_cnt + CW'(req.urgent);
      end
      tcpq_pkg::CMD_DEPART: begin
        ok = (total_cnt != '0);
        ctl.pop_en      = fire && ok;
        total_cnt_next  = total_cnt - CW'(1);
        urgent_cnt_next = urgent_cnt - CW'(slots[0].urgent);
      end
      tcpq_pkg::CMD_REMOVE: begin
        ok = found;
        ctl.del_en      = fire && ok;
        total_cnt_next  = total_cnt - CW'(1);
        urgent_cnt_next = urgent_cnt - CW'(hit_urg[CAPACITY]);
      end
      tcpq_pkg::CMD_QUERY: begin
        ok = found && in_range;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    // queries and failed commands leave the counts alone
    if (!ok || (req.command == tcpq_pkg::CMD_QUERY)) begin
      total_cnt_next  = total_cnt;
      urgent_cnt_next = urgent_cnt;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (accept) state_next = ST_COMPARE;
      ST_COMPARE: state_next = ST_APPLY;
      ST_APPLY: begin
        if (fire) state_next = accept ? ST_COMPARE : ST_IDLE;
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      queue_type <= 1'b0;
      total_cnt  <= '0;
      urgent_cnt <= '0;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        queue_type <= cfg_wr_data;
      end
      if (fire) begin
        total_cnt  <= total_cnt_next;
        urgent_cnt <= urgent_cnt_next;
        res_valid  <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= cmd;
    end
    if (fire) begin
      res.ok            <= ok;
      res.waiting_count <= tcpq_pkg::COUNT_OUT_W'(total_cnt_next);
      res.urgent_count  <= tcpq_pkg::COUNT_OUT_W'(urgent_cnt_next);
    end
  end

endmodule

FILE: hdl/tcpq_checker.sv
// Port-level checks for the two-class priority queue, bound to the top level.
module tcpq_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_stall,
  input logic           res_valid,
  input logic           res_stall,
  input tcpq_pkg::res_t res
);

  // no result is pending right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // urgent entries are a subset of all entries
  a_count_order: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.urgent_count <= res.waiting_count))
    else $error("urgent count exceeds waiting count");

  // one request in flight: the compare cycle always stalls the next request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> cmd_stall)
    else $error("request accepted during compare cycle");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res)))
    else $error("stalled result changed");

endmodule

bind two_class_priority_queue_unit tcpq_checker u_tcpq_checker (.*);
